/* sv/bqe_pkg.sv */
// ----------------------------------------------------------------------------
// bqe_pkg
// Types and constants shared by the billboard quad expander modules.
// ----------------------------------------------------------------------------
package bqe_pkg;

    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 48;
    localparam int VtxNumW   = 18;
    localparam int CordicN   = 15;
    localparam int IterW     = 4;
    localparam int TrigW     = 19;
    localparam int AngleZW   = 18;
    localparam logic signed [TrigW-1:0] CordicX0 = 19'sd39797;
    localparam logic signed [TrigW-1:0] TrigOne  = 19'sd65536;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_UP    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SCALE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_COLOR = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ANGLE = 3'd5;

    // Rotation modes; codes 2 and 3 both select the per-item angle.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SHARED = 2'd1;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [15:0]        item_angle;
        logic               batch_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  vertex_x;
        logic signed [31:0]  vertex_y;
        logic signed [31:0]  vertex_z;
        logic                tex_u;
        logic                tex_v;
        logic [47:0]         vertex_color;
        logic [VtxNumW-1:0]  vertex_number;
        logic                last_corner;
    } t_out_item;

    typedef struct packed {
        logic             load;
        logic             rot_step;
        logic             fix;
        logic             mul1;
        logic             mul2;
        logic             sum;
        logic             item_done;
        logic [IterW-1:0] iter;
        logic [1:0]       corner;
    } t_cmd;

    function automatic logic [13:0] atan_lut(input logic [IterW-1:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/bqe_ctrl.sv */
// ----------------------------------------------------------------------------
// bqe_ctrl
// Sequencer: CORDIC iterations, fold, then three steps and one beat per corner.
// ----------------------------------------------------------------------------
module bqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output bqe_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ROT  = 7'b0000010,
        S_FIX  = 7'b0000100,
        S_MUL1 = 7'b0001000,
        S_MUL2 = 7'b0010000,
        S_SUM  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic [bqe_pkg::IterW-1:0] r_iter, n_iter;
    logic [1:0]                r_corner, n_corner;
    logic                      w_accept, w_beat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_beat      = (r_state == S_OUT) && !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_corner = r_corner;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_ROT;
                    n_iter   = '0;
                    n_corner = '0;
                end
            end
            S_ROT: begin
                if (r_iter == bqe_pkg::IterW'(bqe_pkg::CordicN - 1)) begin
                    n_state = S_FIX;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_FIX:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_corner == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state  = S_MUL1;
                        n_corner = r_corner + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iter   <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_iter   <= n_iter;
            r_corner <= n_corner;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.rot_step  = (r_state == S_ROT);
        o_cmd.fix       = (r_state == S_FIX);
        o_cmd.mul1      = (r_state == S_MUL1);
        o_cmd.mul2      = (r_state == S_MUL2);
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.item_done = w_beat && (r_corner == 2'd3);
        o_cmd.iter      = r_iter;
        o_cmd.corner    = r_corner;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state register not one-hot");
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_iter < bqe_pkg::IterW'(bqe_pkg::CordicN)))
        else $error("CORDIC iteration count out of range");
    a_accept_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ROT) && (r_iter == '0) && (r_corner == '0))
        else $error("accepted item did not start rotation");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.item_done |=> (r_state == S_IDLE))
        else $error("fourth beat did not return to idle");

endmodule

/* sv/bqe_dp.sv */
// ----------------------------------------------------------------------------
// bqe_dp
// Datapath: configuration registers, CORDIC, corner multiply and output register.
// ----------------------------------------------------------------------------
module bqe_dp #(
    parameter int MAX_QUADS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bqe_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [bqe_pkg::CfgDataW-1:0]     i_cfg_data,
    input  bqe_pkg::t_in_item                i_in_data,
    input  bqe_pkg::t_cmd                    i_cmd,
    output bqe_pkg::t_out_item               o_out_data
);

    localparam int CntW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
    localparam int TW   = bqe_pkg::TrigW;
    localparam int ZW   = bqe_pkg::AngleZW;

    logic [47:0] r_up, r_right, r_color;
    logic [15:0] r_scale, r_shared;
    logic [1:0]  r_mode;
    logic [CntW-1:0] r_cnt;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_quad;
    logic signed [TW-1:0] r_x, r_y, r_cos, r_sin;
    logic signed [ZW-1:0] r_z;
    logic signed [34:0] r_kx, r_ky, r_kz;
    logic signed [53:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_oz;
    bqe_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up     <= '0;
            r_right  <= '0;
            r_scale  <= 16'd256;
            r_color  <= '0;
            r_mode   <= bqe_pkg::MODE_NONE;
            r_shared <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bqe_pkg::REG_UP:    r_up     <= i_cfg_data;
                bqe_pkg::REG_RIGHT: r_right  <= i_cfg_data;
                bqe_pkg::REG_SCALE: r_scale  <= i_cfg_data[15:0];
                bqe_pkg::REG_COLOR: r_color  <= i_cfg_data;
                bqe_pkg::REG_MODE:  r_mode   <= i_cfg_data[1:0];
                bqe_pkg::REG_ANGLE: r_shared <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Quad counter; batch_start zeroes it before this item is numbered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load && i_in_data.batch_start) begin
            r_cnt <= '0;
        end else if (i_cmd.item_done) begin
            r_cnt <= (r_cnt == CntW'(MAX_QUADS - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    logic [15:0]          w_angle;
    logic signed [TW-1:0] w_dx, w_dy;
    logic signed [ZW-1:0] w_at;

    assign w_angle = (r_mode == bqe_pkg::MODE_SHARED) ? r_shared : i_in_data.item_angle;
    assign w_dx    = r_y >>> i_cmd.iter;
    assign w_dy    = r_x >>> i_cmd.iter;
    assign w_at    = ZW'(bqe_pkg::atan_lut(i_cmd.iter));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= i_in_data.center_x;
            r_cy   <= i_in_data.center_y;
            r_cz   <= i_in_data.center_z;
            r_quad <= w_angle[15:14];
            r_x    <= bqe_pkg::CordicX0;
            r_y    <= '0;
            r_z    <= ZW'(w_angle[13:0]);
        end else if (i_cmd.rot_step) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    // Quadrant fold by exact quarter turns; no rotation forces the identity.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            if (r_mode == bqe_pkg::MODE_NONE) begin
                r_cos <= bqe_pkg::TrigOne;
                r_sin <= '0;
            end else begin
                case (r_quad)
                    2'd0: begin r_cos <= r_x;  r_sin <= r_y;  end
                    2'd1: begin r_cos <= -r_y; r_sin <= r_x;  end
                    2'd2: begin r_cos <= -r_x; r_sin <= -r_y; end
                    default: begin r_cos <= r_y; r_sin <= -r_x; end
                endcase
            end
        end
    end

    // Corner sign pattern: up is negative on the lower corners, right on the left ones.
    logic               w_neg_up, w_neg_rt;
    logic signed [17:0] w_s [3];
    logic signed [16:0] w_scale;

    assign w_neg_up = (i_cmd.corner == 2'd0) || (i_cmd.corner == 2'd1);
    assign w_neg_rt = (i_cmd.corner == 2'd0) || (i_cmd.corner == 2'd3);
    assign w_scale  = $signed({1'b0, r_scale});

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [17:0] u, r;
            u = 18'($signed(r_up[16*j +: 16]));
            r = 18'($signed(r_right[16*j +: 16]));
            w_s[j] = (w_neg_up ? -u : u) + (w_neg_rt ? -r : r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_kx <= 35'(w_s[0]) * 35'(w_scale);
            r_ky <= 35'(w_s[1]) * 35'(w_scale);
            r_kz <= 35'(w_s[2]) * 35'(w_scale);
        end
    end

    logic signed [34:0] w_kz_r;
    assign w_kz_r = (r_kz + 35'sd64) >>> 7;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_p0 <= 54'(r_kx) * 54'(r_cos);
            r_p1 <= 54'(r_ky) * 54'(r_sin);
            r_p2 <= 54'(r_kx) * 54'(r_sin);
            r_p3 <= 54'(r_ky) * 54'(r_cos);
            r_oz <= 32'(w_kz_r);
        end
    end

    logic signed [54:0] w_ox, w_oy;
    logic [CntW+1:0]    w_vn;

    assign w_ox = 55'(r_p0) - 55'(r_p1) + 55'sd4194304;
    assign w_oy = 55'(r_p2) + 55'(r_p3) + 55'sd4194304;
    assign w_vn = {r_cnt, i_cmd.corner};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_out.vertex_x      <= r_cx + $signed(w_ox[54:23]);
            r_out.vertex_y      <= r_cy + $signed(w_oy[54:23]);
            r_out.vertex_z      <= r_cz + r_oz;
            r_out.tex_u         <= (i_cmd.corner == 2'd1) || (i_cmd.corner == 2'd2);
            r_out.tex_v         <= w_neg_up;
            r_out.vertex_color  <= r_color;
            r_out.vertex_number <= bqe_pkg::VtxNumW'(w_vn);
            r_out.last_corner   <= (i_cmd.corner == 2'd3);
        end
    end

    assign o_out_data = r_out;

endmodule

/* sv/billboard_quad_expander_top.sv */
// ----------------------------------------------------------------------------
// billboard_quad_expander_top
// Expands one particle centre into the four vertices of a camera-facing quad.
// ----------------------------------------------------------------------------
// Input channel: one beat per particle (centre, angle, batch_start), taken
// when i_in_valid is high and o_in_stall is low. Output channel: four beats
// per particle in the order lower-left, lower-right, upper-right, upper-left,
// taken when o_out_valid is high and i_out_stall is low.
// One particle is in flight at a time. After acceptance the sincos CORDIC
// runs its iterations (one iteration per cycle), then a quadrant fold step;
// each corner then passes a scale multiply, a rotate multiply and a sum
// before its beat is shown. o_in_stall is high throughout, and the next
// particle is taken in the idle state after the fourth beat, so a new
// particle is never accepted before the last one's fourth beat is taken.
// When the receiver stalls the output beat holds and the block waits.
// Configuration writes land at once and must only be made while idle.
// Synchronous active-low reset returns to idle, clears the quad counter and
// loads register defaults (scale 2.0 in UQ9.7, all else zero).
// ----------------------------------------------------------------------------
module billboard_quad_expander_top #(
    parameter int MAX_QUADS = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bqe_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bqe_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bqe_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bqe_pkg::t_out_item           o_out_data
);

    bqe_pkg::t_cmd w_cmd;

    bqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    bqe_dp #(
        .MAX_QUADS (MAX_QUADS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_out_data  (o_out_data)
    );

endmodule
